[hdl/a64x_pkg.sv]
// types and constants for the arm64 add/sub, move wide and branch execute block
// no dependencies; used by every module of the block
`default_nettype none

package a64x_pkg;

    // result kind codes
    typedef enum logic [2:0] {
        KIND_ADDSUB = 3'd0,
        KIND_MOVW   = 3'd1,
        KIND_BR     = 3'd2,
        KIND_UNDEF  = 3'd3,
        KIND_PRESET = 3'd4
    } kind_t;

    // item mode codes
    localparam logic MODE_EXEC   = 1'b0;
    localparam logic MODE_PRESET = 1'b1;

    // decode patterns
    localparam logic [5:0]  ADDSUB_OP = 6'b100010;
    localparam logic [5:0]  MOVW_OP   = 6'b100101;
    localparam logic [31:0] BR_MASK   = 32'hFFFF_FC1F;
    localparam logic [31:0] BR_MATCH  = 32'hD61F_0000;

    // move wide opcodes
    localparam logic [1:0] OPC_MOVN = 2'b00;
    localparam logic [1:0] OPC_RSVD = 2'b01;
    localparam logic [1:0] OPC_MOVZ = 2'b10;
    localparam logic [1:0] OPC_MOVK = 2'b11;

    // register 31: stack pointer or zero register
    localparam logic [4:0] SP_INDEX = 5'd31;

    typedef struct packed {
        logic        mode;
        logic [31:0] instruction_word;
        logic [4:0]  load_index;
        logic [63:0] load_value;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic        write_enable;
        logic [4:0]  write_index;
        logic [63:0] write_value;
        logic [3:0]  nzcv;
        logic        branch_taken;
        logic [63:0] branch_target;
    } result_t;

    // register store write port
    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [63:0] data;
    } wr_port_t;

endpackage

`default_nettype wire

[hdl/a64x_regfile.sv]
// 32 x 64 register store (x0..x30 and sp) with two registered read ports
// depends on a64x_pkg for the write port struct
`default_nettype none

module a64x_regfile (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rd_en,
    input  wire logic [4:0]          rd_addr_a,
    input  wire logic [4:0]          rd_addr_b,
    output logic [63:0]              rd_data_a,
    output logic [63:0]              rd_data_b,
    input  wire a64x_pkg::wr_port_t  wr
);

    logic [63:0] mem [32];
    logic [31:0] valid_reg;
    logic [63:0] rd_data_a_reg;
    logic [63:0] rd_data_b_reg;

    // storage write
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // written marks, an unwritten entry reads zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // registered reads with bypass of a same-cycle write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && wr.addr == rd_addr_a)
            begin
                rd_data_a_reg <= wr.data;
            end
            else if (valid_reg[rd_addr_a])
            begin
                rd_data_a_reg <= mem[rd_addr_a];
            end
            else
            begin
                rd_data_a_reg <= '0;
            end

            if (wr.en && wr.addr == rd_addr_b)
            begin
                rd_data_b_reg <= wr.data;
            end
            else if (valid_reg[rd_addr_b])
            begin
                rd_data_b_reg <= mem[rd_addr_b];
            end
            else
            begin
                rd_data_b_reg <= '0;
            end
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

`default_nettype wire

[hdl/a64x_exec.sv]
// decode and execute of one item: add/sub immediate, move wide, br, preset
// depends on a64x_pkg for item, result and code definitions
`default_nettype none

module a64x_exec (
    input  wire a64x_pkg::item_t   item,
    input  wire logic [63:0]       rn_data,
    input  wire logic [63:0]       rd_data,
    input  wire logic [3:0]        flags,
    output a64x_pkg::result_t      result
);

    logic [31:0] w;
    logic [4:0]  rn;
    logic [4:0]  rdst;
    logic        sf;

    // add/sub fields and datapath
    logic        as_sub;
    logic        as_s;
    logic [63:0] as_imm;
    logic [63:0] as_mask;
    logic [63:0] as_sign;
    logic [63:0] as_n;
    logic [63:0] as_m;
    logic [63:0] as_d;
    logic        fl_n;
    logic        fl_z;
    logic        fl_c;
    logic        fl_v;

    // move wide fields and datapath
    logic [1:0]  mw_opc;
    logic [1:0]  mw_hw;
    logic [5:0]  mw_shift;
    logic [63:0] mw_imm;
    logic [63:0] mw_keep;
    logic [63:0] mw_r;
    logic        mw_ok;

    assign w    = item.instruction_word;
    assign rn   = w[9:5];
    assign rdst = w[4:0];
    assign sf   = w[31];

    // add/sub immediate
    always_comb
    begin
        as_sub  = w[30];
        as_s    = w[29];
        as_imm  = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
        as_mask = sf ? {64{1'b1}} : {32'd0, {32{1'b1}}};
        as_sign = sf ? {1'b1, 63'd0} : {32'd0, 1'b1, 31'd0};
        as_n    = rn_data & as_mask;
        as_m    = as_imm & as_mask;
        as_d    = (as_sub ? (as_n - as_m) : (as_n + as_m)) & as_mask;
        fl_n    = |(as_d & as_sign);
        fl_z    = (as_d == 64'd0);
        if (as_sub)
        begin
            fl_c = (as_n >= as_m);
            fl_v = |(((as_d ^ as_n) & (as_n ^ as_m)) & as_sign);
        end
        else
        begin
            fl_c = (as_d < as_n);
            fl_v = |(((as_d ^ as_n) & ~(as_n ^ as_m)) & as_sign);
        end
    end

    // move wide
    always_comb
    begin
        mw_opc   = w[30:29];
        mw_hw    = w[22:21];
        mw_shift = {mw_hw, 4'd0};
        mw_imm   = {48'd0, w[20:5]} << mw_shift;
        mw_keep  = (rdst == a64x_pkg::SP_INDEX) ? 64'd0 : rd_data;
        mw_ok    = (mw_opc != a64x_pkg::OPC_RSVD) && !(!sf && mw_hw[1]);
        case (mw_opc)
            a64x_pkg::OPC_MOVN: mw_r = ~mw_imm;
            a64x_pkg::OPC_MOVK: mw_r = (mw_keep & ~({48'd0, 16'hFFFF} << mw_shift)) | mw_imm;
            default:            mw_r = mw_imm;
        endcase
        if (!sf)
        begin
            mw_r = {32'd0, mw_r[31:0]};
        end
    end

    // result selection
    always_comb
    begin
        result               = '0;
        result.kind          = a64x_pkg::KIND_UNDEF;
        result.nzcv          = flags;
        if (item.mode == a64x_pkg::MODE_PRESET)
        begin
            result.kind         = a64x_pkg::KIND_PRESET;
            result.write_enable = 1'b1;
            result.write_index  = item.load_index;
            result.write_value  = item.load_value;
        end
        else if (w[28:23] == a64x_pkg::ADDSUB_OP)
        begin
            result.kind = a64x_pkg::KIND_ADDSUB;
            if (as_s)
            begin
                result.nzcv = {fl_n, fl_z, fl_c, fl_v};
            end
            if (!(as_s && rdst == a64x_pkg::SP_INDEX))
            begin
                result.write_enable = 1'b1;
                result.write_index  = rdst;
                result.write_value  = as_d;
            end
        end
        else if (w[28:23] == a64x_pkg::MOVW_OP)
        begin
            if (mw_ok)
            begin
                result.kind = a64x_pkg::KIND_MOVW;
                if (rdst != a64x_pkg::SP_INDEX)
                begin
                    result.write_enable = 1'b1;
                    result.write_index  = rdst;
                    result.write_value  = mw_r;
                end
            end
        end
        else if ((w & a64x_pkg::BR_MASK) == a64x_pkg::BR_MATCH)
        begin
            result.kind          = a64x_pkg::KIND_BR;
            result.branch_taken  = 1'b1;
            result.branch_target = (rn == a64x_pkg::SP_INDEX) ? 64'd0 : rn_data;
        end
    end

endmodule

`default_nettype wire

[hdl/arm64_addsub_movwide_branch_execute.sv]
// arm64 add/sub immediate, move wide and br execute unit
// transfer reads operands into the first stage; execute fills the result register
// throughput: one item per cycle while the output is not stalled; the register
// store read bypasses the write of the item ahead, so dependents go back to back
// reset: register store reads zero through per-entry written bits, flags clear
// to zero, both pipeline stages empty; depends on a64x_pkg, a64x_regfile, a64x_exec
`default_nettype none

module arm64_addsub_movwide_branch_execute (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire a64x_pkg::item_t    item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output a64x_pkg::result_t       result
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    a64x_pkg::item_t     s1_item_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    a64x_pkg::result_t   out_item_reg;
    logic [3:0]          flags_reg;
    logic [3:0]          flags_next;

    logic                item_fire;
    logic                stage_fire;
    logic [63:0]         rn_data;
    logic [63:0]         rd_data;
    a64x_pkg::result_t   exec_result;
    a64x_pkg::wr_port_t  wr;

    // handshake control
    assign stage_fire = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || stage_fire;
    assign item_fire  = item_valid && item_ready;

    assign s1_valid_next  = item_fire ? 1'b1 : (stage_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = stage_fire ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);
    assign flags_next     = stage_fire ? exec_result.nzcv : flags_reg;

    // register store write from the committing item
    assign wr.en   = stage_fire && exec_result.write_enable;
    assign wr.addr = exec_result.write_index;
    assign wr.data = exec_result.write_value;

    a64x_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (item_fire),
        .rd_addr_a (item.instruction_word[9:5]),
        .rd_addr_b (item.instruction_word[4:0]),
        .rd_data_a (rn_data),
        .rd_data_b (rd_data),
        .wr        (wr)
    );

    a64x_exec u_exec (
        .item    (s1_item_reg),
        .rn_data (rn_data),
        .rd_data (rd_data),
        .flags   (flags_reg),
        .result  (exec_result)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= 4'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_item_reg <= item;
        end
        if (stage_fire)
        begin
            out_item_reg <= exec_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // flags move only when an item commits
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_fire |=> $stable(flags_reg))
        else $error("flags changed without a committing item");

    // a committed item always shows up as a result
    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire |=> result_valid)
        else $error("committed item did not reach the result register");

    // br and undefined results never write the register store
    a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == a64x_pkg::KIND_BR ||
                         result.kind == a64x_pkg::KIND_UNDEF)
        |-> !result.write_enable && result.write_value == 64'd0)
        else $error("br or undefined item reported a register write");

    // only br reports a branch
    a_branch_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.branch_taken |-> result.kind == a64x_pkg::KIND_BR)
        else $error("branch reported for a non-br item");

    // an empty first stage always takes a transfer
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> item_ready)
        else $error("input stalled while the first stage is empty");

endmodule

`default_nettype wire
